>>> rtl/cpb_pkg.sv
// Package for the sprite pixel blend block: register map, reset values,
// configuration and word types, channel helpers. No dependencies.
package cpb_pkg;

    // Register file geometry
    localparam int REG_COUNT = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Color geometry
    localparam int COLOR_W = 16;
    localparam int CHAN_W  = 5;
    localparam int MULT_W  = 4;
    localparam int SHIFT_W = 3;
    localparam int PROD_W  = CHAN_W + MULT_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int NCHAN   = 3;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_OPAQUE_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_SELECT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_MULTIPLIER       = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIVIDE_SHIFT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FINAL_HALVE      = 3'd4;
    localparam logic [IDX_W-1:0] REG_ADD_CONSTANT     = 3'd5;
    localparam logic [IDX_W-1:0] REG_XOR_MODE         = 3'd6;
    localparam logic [IDX_W-1:0] REG_ZERO_TRANSPARENT = 3'd7;

    // Second source codes, source_select[1:0]
    localparam logic [1:0] SRC2_NONE   = 2'd0;
    localparam logic [1:0] SRC2_CONST  = 2'd1;
    localparam logic [1:0] SRC2_FRAME  = 2'd2;
    localparam logic [1:0] SRC2_SPRITE = 2'd3;

    // Bit of source_select that picks the framebuffer as first source
    localparam int SEL_FIRST_FB = 2;

    typedef struct packed {
        logic               opaque_mode;
        logic [2:0]         source_select;
        logic [MULT_W-1:0]  multiplier;
        logic [SHIFT_W-1:0] divide_shift;
        logic               final_halve;
        logic [CHAN_W-1:0]  add_constant;
        logic               xor_mode;
        logic               zero_transparent;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        opaque_mode:      1'b1,
        source_select:    3'd0,
        multiplier:       4'd8,
        divide_shift:     3'd3,
        final_halve:      1'b0,
        add_constant:     5'd0,
        xor_mode:         1'b0,
        zero_transparent: 1'b1
    };

    typedef struct packed {
        logic [COLOR_W-1:0] sprite_color;
        logic [COLOR_W-1:0] frame_color;
        logic               already_blended;
    } in_word_t;

    typedef struct packed {
        logic               write_enable;
        logic [COLOR_W-1:0] out_color;
        logic               mark_stencil;
    } out_word_t;

    // Channel k of an RGB555 color: 0 blue, 1 green, 2 red
    function automatic logic [CHAN_W-1:0] get_chan(input logic [COLOR_W-1:0] c,
                                                   input int k);
        logic [COLOR_W-1:0] sh;
        sh = c >> (k * CHAN_W);
        return sh[CHAN_W-1:0];
    endfunction

endpackage

>>> rtl/cpb_regs.sv
// APB-style configuration registers of the pixel blend block.
// Depends on cpb_pkg.
module cpb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpb_pkg::ADDR_W-1:0] paddr,
    input  logic [cpb_pkg::DATA_W-1:0] pwdata,
    output logic [cpb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cpb_pkg::cfg_t              cfg
);
    import cpb_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_OPAQUE_MODE:      cfg_next.opaque_mode      = pwdata[0];
                REG_SOURCE_SELECT:    cfg_next.source_select    = pwdata[2:0];
                REG_MULTIPLIER:       cfg_next.multiplier       = pwdata[MULT_W-1:0];
                REG_DIVIDE_SHIFT:     cfg_next.divide_shift     = pwdata[SHIFT_W-1:0];
                REG_FINAL_HALVE:      cfg_next.final_halve      = pwdata[0];
                REG_ADD_CONSTANT:     cfg_next.add_constant     = pwdata[CHAN_W-1:0];
                REG_XOR_MODE:         cfg_next.xor_mode         = pwdata[0];
                REG_ZERO_TRANSPARENT: cfg_next.zero_transparent = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (idx)
            REG_OPAQUE_MODE:      prdata[0]            = cfg_reg.opaque_mode;
            REG_SOURCE_SELECT:    prdata[2:0]          = cfg_reg.source_select;
            REG_MULTIPLIER:       prdata[MULT_W-1:0]   = cfg_reg.multiplier;
            REG_DIVIDE_SHIFT:     prdata[SHIFT_W-1:0]  = cfg_reg.divide_shift;
            REG_FINAL_HALVE:      prdata[0]            = cfg_reg.final_halve;
            REG_ADD_CONSTANT:     prdata[CHAN_W-1:0]   = cfg_reg.add_constant;
            REG_XOR_MODE:         prdata[0]            = cfg_reg.xor_mode;
            REG_ZERO_TRANSPARENT: prdata[0]            = cfg_reg.zero_transparent;
            default:              prdata               = '0;
        endcase
    end

endmodule

>>> rtl/cel_pixel_blend_top.sv
// Top level of the sprite pixel blend block: three-stage blend pipeline.
// Depends on cpb_pkg and cpb_regs.
//
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_data       | sprite, framebuffer, blended
//  result  | m_valid, m_ready, m_data       | write enable, color, stencil
//  config  | psel..pready (APB-style)       | 8 registers at 4*index
//
// One word per cycle enters while m_ready does not stall the pipe; each word
// passes the registers of stage 1 (multiply), stage 2 (shift/combine/saturate)
// and stage 3 (pack/zero test), and m_valid is the valid bit of stage 3.
// Each stage holds a valid bit and advances when the next stage is empty or
// moving, so a stalled m_ready fills the pipe without loss or repeats.
// Reset (synchronous, aresetn low) empties the pipe and loads register defaults.
module cel_pixel_blend_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cpb_pkg::in_word_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cpb_pkg::out_word_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cpb_pkg::ADDR_W-1:0] paddr,
    input  logic [cpb_pkg::DATA_W-1:0] pwdata,
    output logic [cpb_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import cpb_pkg::*;

    typedef struct packed {
        logic                          opaque;
        logic [COLOR_W-1:0]            sprite;
        logic                          blocked;
        logic                          needs_fb;
        logic [NCHAN-1:0][PROD_W-1:0]  prod;
        logic [NCHAN-1:0][CHAN_W-1:0]  second;
    } st1_t;

    typedef struct packed {
        logic                          opaque;
        logic [COLOR_W-1:0]            sprite;
        logic                          blocked;
        logic                          needs_fb;
        logic [NCHAN-1:0][CHAN_W-1:0]  chan;
    } st2_t;

    cfg_t      cfg;
    st1_t      st1_reg, st1_next;
    st2_t      st2_reg, st2_next;
    out_word_t st3_reg, st3_next;
    logic      v1_reg, v2_reg, v3_reg;
    logic      v1_next, v2_next, v3_next;
    logic      rdy1, rdy2, rdy3;

    cpb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage handshake: a stage takes a word when empty or draining
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v3_reg;
    assign m_data  = st3_reg;

    assign v1_next = rdy1 ? s_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;

    // Stage 1: source selection and per-channel multiply
    always_comb begin
        logic [COLOR_W-1:0] first;
        logic [1:0]         sel2;
        logic               first_fb;
        first_fb = cfg.source_select[SEL_FIRST_FB];
        sel2     = cfg.source_select[1:0];
        first    = first_fb ? s_data.frame_color : s_data.sprite_color;
        st1_next.opaque   = cfg.opaque_mode;
        st1_next.sprite   = s_data.sprite_color;
        st1_next.needs_fb = first_fb || (sel2 == SRC2_FRAME);
        st1_next.blocked  = st1_next.needs_fb && s_data.already_blended;
        for (int k = 0; k < NCHAN; k++) begin
            st1_next.prod[k] = {{MULT_W{1'b0}}, get_chan(first, k)}
                             * {{CHAN_W{1'b0}}, cfg.multiplier};
            case (sel2)
                SRC2_NONE:   st1_next.second[k] = '0;
                SRC2_CONST:  st1_next.second[k] = cfg.add_constant;
                SRC2_FRAME:  st1_next.second[k] = get_chan(s_data.frame_color, k);
                SRC2_SPRITE: st1_next.second[k] = get_chan(s_data.sprite_color, k);
                default:     st1_next.second[k] = '0;
            endcase
        end
    end

    // Stage 2: divide, combine, halve, saturate
    always_comb begin
        logic [PROD_W-1:0] shifted;
        logic [SUM_W-1:0]  comb;
        logic [SUM_W-1:0]  halved;
        shifted = '0;
        comb    = '0;
        halved  = '0;
        st2_next.opaque   = st1_reg.opaque;
        st2_next.sprite   = st1_reg.sprite;
        st2_next.blocked  = st1_reg.blocked;
        st2_next.needs_fb = st1_reg.needs_fb;
        for (int k = 0; k < NCHAN; k++) begin
            shifted = st1_reg.prod[k] >> cfg.divide_shift;
            if (cfg.xor_mode) begin
                comb = {1'b0, shifted ^ {{MULT_W{1'b0}}, st1_reg.second[k]}};
            end else begin
                comb = {1'b0, shifted} + {{(SUM_W-CHAN_W){1'b0}}, st1_reg.second[k]};
            end
            halved = cfg.final_halve ? (comb >> 1) : comb;
            if (halved > {{(SUM_W-CHAN_W){1'b0}}, CHAN_MAX}) begin
                st2_next.chan[k] = CHAN_MAX;
            end else begin
                st2_next.chan[k] = halved[CHAN_W-1:0];
            end
        end
    end

    // Stage 3: pack, zero test, result word
    always_comb begin
        logic [COLOR_W-1:0] color;
        color = {1'b0, st2_reg.chan[2], st2_reg.chan[1], st2_reg.chan[0]};
        st3_next = '0;
        if (st2_reg.opaque) begin
            if (!(st2_reg.sprite == '0 && cfg.zero_transparent)) begin
                st3_next.write_enable = 1'b1;
                st3_next.out_color    = st2_reg.sprite;
            end
        end else if (!st2_reg.blocked) begin
            if (!(color == '0 && cfg.zero_transparent)) begin
                st3_next.write_enable = 1'b1;
                st3_next.out_color    = color;
                st3_next.mark_stencil = st2_reg.needs_fb;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage data, loaded only when a word moves in
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            st1_reg <= st1_next;
        end
        if (rdy2 && v1_reg) begin
            st2_reg <= st2_next;
        end
        if (rdy3 && v2_reg) begin
            st3_reg <= st3_next;
        end
    end

endmodule
